// ----- rtl/tks_pkg.sv -----
// ============================================================================
// tks_pkg
// Shared types and constants of the trie keyword store.
// ============================================================================
package tks_pkg;

    localparam int ACTION_W   = 2;
    localparam int LETTER_W   = 5;
    localparam int STATUS_W   = 2;
    localparam int NODE_IDX_W = 10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_STEP,
        S_ALLOC,
        S_FREAD,
        S_FINAL,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/trie_keyword_store_core.sv -----
// ============================================================================
// trie_keyword_store_core
// Trie over a fixed node pool, fed one letter per item, with insert, lookup
// and clear actions. Child links and node rows live in two synchronous RAMs.
// ============================================================================
//
//  Channel   Signals                               Direction
//  item      item_valid/item_ready, action, letter, no_letter, last   in
//  result    result_valid/result_ready, status, node_index            out
//
// A letter item that is not the last of its keyword has the node-row and link
// RAMs read as it is taken and is applied in S_STEP; when its letter
// allocates a node, S_ALLOC follows, where the new node's row is cleared.
// A final item then goes through S_FREAD, where the reached node's row is
// read again for the word-end bit, and S_FINAL. A clear goes to S_EMIT.
// After reset the root row is cleared in S_INIT before items are taken.
// A stalled result waits in the output register while the next item is taken.

module trie_keyword_store_core #(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [tks_pkg::ACTION_W-1:0]       action,
    input  logic [tks_pkg::LETTER_W-1:0]       letter,
    input  logic                               no_letter,
    input  logic                               last,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [tks_pkg::STATUS_W-1:0]       status,
    output logic [tks_pkg::NODE_IDX_W-1:0]     node_index
);

    localparam int NW         = $clog2(NODE_COUNT);
    localparam int UW         = NW + 1;
    localparam int LW         = $clog2(ALPHABET);
    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
    localparam int SW         = $clog2(LINK_DEPTH);
    localparam int RW         = ALPHABET + 1;

    logic [NW-1:0] link_mem [LINK_DEPTH];
    logic [RW-1:0] node_mem [NODE_COUNT];

    tks_pkg::state_t state_reg, state_next;

    logic [NW-1:0]                   walk_node_reg, walk_node_next;
    logic                            walk_failed_reg, walk_failed_next;
    logic [UW-1:0]                   nodes_used_reg, nodes_used_next;
    logic                            insert_reg, insert_next;
    logic                            last_reg, last_next;
    logic                            no_letter_reg, no_letter_next;
    logic [LW-1:0]                   letter_reg, letter_next;
    logic [SW-1:0]                   slot_reg, slot_next;
    logic [tks_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [NW-1:0]                   res_node_reg, res_node_next;
    logic                            result_valid_reg, result_valid_next;
    logic [tks_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [tks_pkg::NODE_IDX_W-1:0]  node_index_reg, node_index_next;

    logic [NW-1:0] link_rd_reg;
    logic [RW-1:0] node_rd_reg;

    logic          node_we;
    logic [NW-1:0] node_waddr;
    logic [RW-1:0] node_wdata;
    logic          link_we;
    logic [NW-1:0] link_wdata;

    logic [LW-1:0] letter_sat;
    logic [SW-1:0] slot_comb;
    logic          accept;
    logic          has_room;

    assign letter_sat = (32'(letter) >= ALPHABET) ? LW'(ALPHABET - 1) : LW'(letter);
    assign slot_comb  = SW'(walk_node_reg) * SW'(ALPHABET) + SW'(letter_sat);
    assign item_ready = (state_reg == tks_pkg::S_IDLE);
    assign accept     = item_valid && item_ready;
    assign has_room   = (nodes_used_reg < UW'(NODE_COUNT));

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign node_index   = node_index_reg;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[walk_node_reg];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[slot_reg] <= link_wdata;
        end
        link_rd_reg <= link_mem[slot_comb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tks_pkg::S_INIT;
            walk_node_reg    <= '0;
            walk_failed_reg  <= 1'b0;
            nodes_used_reg   <= UW'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_node_reg    <= walk_node_next;
            walk_failed_reg  <= walk_failed_next;
            nodes_used_reg   <= nodes_used_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        insert_reg     <= insert_next;
        last_reg       <= last_next;
        no_letter_reg  <= no_letter_next;
        letter_reg     <= letter_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        status_reg     <= status_next;
        node_index_reg <= node_index_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        walk_node_next    = walk_node_reg;
        walk_failed_next  = walk_failed_reg;
        nodes_used_next   = nodes_used_reg;
        insert_next       = insert_reg;
        last_next         = last_reg;
        no_letter_next    = no_letter_reg;
        letter_next       = letter_reg;
        slot_next         = slot_reg;
        res_status_next   = res_status_reg;
        res_node_next     = res_node_reg;
        result_valid_next = result_valid_reg && !result_ready;
        status_next       = status_reg;
        node_index_next   = node_index_reg;
        node_we           = 1'b0;
        node_waddr        = walk_node_reg;
        node_wdata        = '0;
        link_we           = 1'b0;
        link_wdata        = nodes_used_reg[NW-1:0];

        case (state_reg)
            tks_pkg::S_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = '0;
                state_next = tks_pkg::S_IDLE;
            end

            tks_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        tks_pkg::ACT_INSERT, tks_pkg::ACT_LOOKUP:
                        begin
                            insert_next    = (action == tks_pkg::ACT_INSERT);
                            last_next      = last;
                            no_letter_next = no_letter;
                            letter_next    = letter_sat;
                            slot_next      = slot_comb;
                            state_next     = tks_pkg::S_STEP;
                        end
                        tks_pkg::ACT_CLEAR:
                        begin
                            node_we          = 1'b1;
                            node_waddr       = '0;
                            nodes_used_next  = UW'(1);
                            walk_node_next   = '0;
                            walk_failed_next = 1'b0;
                            res_status_next  = tks_pkg::ST_OK;
                            res_node_next    = '0;
                            state_next       = tks_pkg::S_EMIT;
                        end
                        default:
                        begin
                            state_next = tks_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            tks_pkg::S_STEP:
            begin
                state_next = last_reg ? tks_pkg::S_FREAD : tks_pkg::S_IDLE;
                if (!no_letter_reg && !walk_failed_reg)
                begin
                    if (node_rd_reg[letter_reg])
                    begin
                        walk_node_next = link_rd_reg;
                    end
                    else if (insert_reg && has_room)
                    begin
                        node_we         = 1'b1;
                        node_wdata      = node_rd_reg | (RW'(1) << letter_reg);
                        link_we         = 1'b1;
                        walk_node_next  = nodes_used_reg[NW-1:0];
                        nodes_used_next = nodes_used_reg + UW'(1);
                        state_next      = tks_pkg::S_ALLOC;
                    end
                    else
                    begin
                        walk_failed_next = 1'b1;
                    end
                end
            end

            tks_pkg::S_ALLOC:
            begin
                node_we    = 1'b1;
                state_next = last_reg ? tks_pkg::S_FREAD : tks_pkg::S_IDLE;
            end

            tks_pkg::S_FREAD:
            begin
                state_next = tks_pkg::S_FINAL;
            end

            tks_pkg::S_FINAL:
            begin
                if (insert_reg)
                begin
                    if (walk_failed_reg)
                    begin
                        res_status_next = tks_pkg::ST_FULL;
                        res_node_next   = '0;
                    end
                    else
                    begin
                        node_we         = 1'b1;
                        node_wdata      = node_rd_reg | (RW'(1) << ALPHABET);
                        res_status_next = tks_pkg::ST_OK;
                        res_node_next   = walk_node_reg;
                    end
                end
                else if (!walk_failed_reg && node_rd_reg[ALPHABET])
                begin
                    res_status_next = tks_pkg::ST_OK;
                    res_node_next   = walk_node_reg;
                end
                else
                begin
                    res_status_next = tks_pkg::ST_MISS;
                    res_node_next   = '0;
                end
                walk_node_next   = '0;
                walk_failed_next = 1'b0;
                state_next       = tks_pkg::S_EMIT;
            end

            tks_pkg::S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    status_next       = res_status_reg;
                    node_index_next   = tks_pkg::NODE_IDX_W'(res_node_reg);
                    state_next        = tks_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tks_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg >= UW'(1)) && (nodes_used_reg <= UW'(NODE_COUNT)))
        else $error("node count out of range");

    a_walk_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        UW'(walk_node_reg) < nodes_used_reg)
        else $error("walk points at an unallocated node");

    a_alloc_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tks_pkg::S_ALLOC) |-> ($past(state_reg) == tks_pkg::S_STEP))
        else $error("allocation without a step");

    a_clear_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == tks_pkg::ACT_CLEAR))
        |=> ((nodes_used_reg == UW'(1)) && (walk_node_reg == '0) && !walk_failed_reg))
        else $error("clear did not reset the store");

    a_fail_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (status_reg != tks_pkg::ST_OK)) |-> (node_index_reg == '0))
        else $error("failed result carries a node");
`endif

endmodule
